### rtl/core/scfp_pkg.sv
// scfp_pkg: shared types and constants for the sum-checked frame parser
// no dependencies; imported by scfp_parser, scfp_out_buf and the top level
package scfp_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_FIRST  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_SECOND = 1'd1;

   localparam logic [BYTE_W-1:0] HEADER_FIRST_RESET  = 8'hFE;
   localparam logic [BYTE_W-1:0] HEADER_SECOND_RESET = 8'hEF;

   localparam logic [BYTE_W-1:0] MIN_LENGTH   = 8'd9;
   localparam logic [BYTE_W-1:0] ID_HEARTBEAT = 8'h00;
   localparam logic [BYTE_W-1:0] ID_GIMBAL    = 8'h11;

   localparam logic [BYTE_W-1:0] IDX_SEQUENCE = 8'd3;
   localparam logic [BYTE_W-1:0] IDX_MESSAGE  = 8'd6;

   localparam logic [STATUS_W-1:0] STATUS_GOOD      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SUM   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SHORT_LEN = 2'd2;

   typedef struct packed {
      logic [STATUS_W-1:0] frame_status;
      logic [BYTE_W-1:0]   message_id;
      logic [BYTE_W-1:0]   sequence_res;
      logic [BYTE_W-1:0]   frame_length;
      logic [COUNT_W-1:0]  heartbeat_count;
      logic [COUNT_W-1:0]  gimbal_count;
   } scfp_result_type;

endpackage

### rtl/core/scfp_parser.sv
// scfp_parser: per-byte frame state machine, running sum and frame counters
// holds the sync byte registers; depends on scfp_pkg
module scfp_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [scfp_pkg::BYTE_W-1:0]     rx_byte,
   input  logic                            csr_write_enable,
   input  logic [scfp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [scfp_pkg::BYTE_W-1:0]     csr_write_data,
   output logic                            result_valid,
   output scfp_pkg::scfp_result_type       result
);
   import scfp_pkg::*;

   typedef enum logic [2:0] {
      PH_HUNT1,
      PH_HUNT2,
      PH_LEN,
      PH_BODY,
      PH_CKL,
      PH_CKH
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [BYTE_W-1:0]    index_ff, index_in;
   logic [BYTE_W-1:0]    length_ff, length_in;
   logic [COUNT_W-1:0]   sum_ff, sum_in;
   logic [BYTE_W-1:0]    check_low_ff, check_low_in;
   logic [BYTE_W-1:0]    sequence_ff, sequence_in;
   logic [BYTE_W-1:0]    message_ff, message_in;
   logic [COUNT_W-1:0]   heartbeat_ff, heartbeat_in;
   logic [COUNT_W-1:0]   gimbal_ff, gimbal_in;
   logic [BYTE_W-1:0]    header_first_ff, header_second_ff;
   logic [COUNT_W-1:0]   sum_plus;
   logic [BYTE_W-1:0]    index_next;
   logic [BYTE_W:0]      index_end;
   logic                 sum_good;

   assign sum_plus   = sum_ff + {{(COUNT_W-BYTE_W){1'b0}}, rx_byte};
   assign index_next = index_ff + 8'd1;
   assign index_end  = {1'b0, index_next} + 9'd2;
   assign sum_good   = (check_low_ff == sum_ff[BYTE_W-1:0]) &&
                       (rx_byte == sum_ff[COUNT_W-1:BYTE_W]);

   always_comb begin
      phase_in     = phase_ff;
      index_in     = index_ff;
      length_in    = length_ff;
      sum_in       = sum_ff;
      check_low_in = check_low_ff;
      sequence_in  = sequence_ff;
      message_in   = message_ff;
      heartbeat_in = heartbeat_ff;
      gimbal_in    = gimbal_ff;
      result_valid = 1'b0;
      result.frame_status = STATUS_GOOD;
      result.message_id   = message_ff;
      result.sequence_res = sequence_ff;
      result.frame_length = length_ff;
      unique case (phase_ff)
         PH_HUNT2: begin
            if (rx_byte == header_second_ff) begin
               sum_in   = sum_plus;
               index_in = 8'd2;
               phase_in = PH_LEN;
            end else if (rx_byte == header_first_ff) begin
               sum_in   = {{(COUNT_W-BYTE_W){1'b0}}, rx_byte};
               index_in = 8'd1;
               phase_in = PH_HUNT2;
            end else begin
               index_in = '0;
               phase_in = PH_HUNT1;
            end
         end
         PH_LEN: begin
            length_in = rx_byte;
            if (rx_byte < MIN_LENGTH) begin
               index_in     = '0;
               phase_in     = PH_HUNT1;
               result_valid = 1'b1;
               result.frame_status = STATUS_SHORT_LEN;
               result.message_id   = '0;
               result.sequence_res = '0;
               result.frame_length = rx_byte;
            end else begin
               sum_in   = sum_plus;
               index_in = 8'd3;
               phase_in = PH_BODY;
            end
         end
         PH_BODY: begin
            if (index_ff == IDX_SEQUENCE) begin
               sequence_in = rx_byte;
            end else if (index_ff == IDX_MESSAGE) begin
               message_in = rx_byte;
            end
            sum_in   = sum_plus;
            index_in = index_next;
            if (index_end >= {1'b0, length_ff}) begin
               phase_in = PH_CKL;
            end
         end
         PH_CKL: begin
            check_low_in = rx_byte;
            phase_in     = PH_CKH;
         end
         PH_CKH: begin
            index_in     = '0;
            phase_in     = PH_HUNT1;
            result_valid = 1'b1;
            if (sum_good) begin
               if (message_ff == ID_HEARTBEAT) begin
                  heartbeat_in = heartbeat_ff + 16'd1;
               end else if (message_ff == ID_GIMBAL) begin
                  gimbal_in = gimbal_ff + 16'd1;
               end
            end else begin
               result.frame_status = STATUS_BAD_SUM;
            end
         end
         default: begin
            if (rx_byte == header_first_ff) begin
               sum_in   = {{(COUNT_W-BYTE_W){1'b0}}, rx_byte};
               index_in = 8'd1;
               phase_in = PH_HUNT2;
            end else begin
               index_in = '0;
               phase_in = PH_HUNT1;
            end
         end
      endcase
      result.heartbeat_count = heartbeat_in;
      result.gimbal_count    = gimbal_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT1;
         index_ff     <= '0;
         length_ff    <= '0;
         sum_ff       <= '0;
         check_low_ff <= '0;
         sequence_ff  <= '0;
         message_ff   <= '0;
         heartbeat_ff <= '0;
         gimbal_ff    <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         index_ff     <= index_in;
         length_ff    <= length_in;
         sum_ff       <= sum_in;
         check_low_ff <= check_low_in;
         sequence_ff  <= sequence_in;
         message_ff   <= message_in;
         heartbeat_ff <= heartbeat_in;
         gimbal_ff    <= gimbal_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_first_ff  <= HEADER_FIRST_RESET;
         header_second_ff <= HEADER_SECOND_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HEADER_FIRST:  header_first_ff  <= csr_write_data;
            CSR_HEADER_SECOND: header_second_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // a result only comes out of the length or high checksum byte
   assert property (@(posedge clock) disable iff (reset)
      result_valid |-> (phase_ff == PH_LEN || phase_ff == PH_CKH))
      else $error("scfp_parser: result outside frame end");

   // hunting always parks the byte position at zero
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HUNT1) |-> (index_ff == '0))
      else $error("scfp_parser: byte index not cleared while hunting");

   // counters move only on a good high checksum byte
   assert property (@(posedge clock) disable iff (reset)
      (heartbeat_ff != $past(heartbeat_ff) || gimbal_ff != $past(gimbal_ff))
         |-> $past(accept && phase_ff == PH_CKH && sum_good))
      else $error("scfp_parser: counter moved outside a good frame");

endmodule

### rtl/core/scfp_out_buf.sv
// scfp_out_buf: result register with one skid entry behind it
// depends on scfp_pkg for the result struct
module scfp_out_buf (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  scfp_pkg::scfp_result_type  in_data,
   output logic                       full,
   output logic                       out_valid,
   input  logic                       out_stall,
   output scfp_pkg::scfp_result_type  out_data
);
   import scfp_pkg::*;

   logic            out_valid_ff, skid_valid_ff;
   scfp_result_type out_data_ff, skid_data_ff;
   logic            take;

   assign take      = out_valid_ff && !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || take) begin
         out_valid_ff <= in_valid;
      end else if (in_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (!out_valid_ff || take) begin
         out_data_ff <= in_data;
      end else begin
         skid_data_ff <= in_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("scfp_out_buf: skid holds data with empty output");

   assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && out_stall && in_valid))
      else $error("scfp_out_buf: skid filled without a stalled output");

   assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && take) |=> (out_valid_ff && out_data_ff == $past(skid_data_ff)))
      else $error("scfp_out_buf: skid entry lost on drain");

endmodule

### rtl/core/sum_checked_frame_parser_unit.sv
// sum_checked_frame_parser_unit: top level of the sum-checked serial frame parser
// instantiates scfp_parser and scfp_out_buf; depends on scfp_pkg
//
//   channel   direction  ports                                      moves
//   req       in         req_valid req_stall req_rx_byte            one received byte
//   rsp       out        rsp_valid rsp_stall rsp_*                  one frame report
//   csr       in         csr_write_enable csr_index csr_write_data  sync byte registers
//
// one byte per cycle while req_stall is low; the state update is a single pass
// from the parser registers to the result register, and a report is registered
// on the byte that ends a frame (length byte below 9 or high checksum byte)
// req_stall rises only while both the result register and its skid entry hold
// reports; reset is synchronous and clears parser state, counters and sync
// bytes to 0xFE / 0xEF
module sum_checked_frame_parser_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [scfp_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [scfp_pkg::STATUS_W-1:0]    rsp_frame_status,
   output logic [scfp_pkg::BYTE_W-1:0]      rsp_message_id,
   output logic [scfp_pkg::BYTE_W-1:0]      rsp_sequence_res,
   output logic [scfp_pkg::BYTE_W-1:0]      rsp_frame_length,
   output logic [scfp_pkg::COUNT_W-1:0]     rsp_heartbeat_count,
   output logic [scfp_pkg::COUNT_W-1:0]     rsp_gimbal_count,
   input  logic                             csr_write_enable,
   input  logic [scfp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [scfp_pkg::BYTE_W-1:0]      csr_write_data
);
   import scfp_pkg::*;

   logic            accept;
   logic            result_valid;
   logic            buf_full;
   scfp_result_type result;
   scfp_result_type rsp_data;

   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   scfp_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .rx_byte          (req_rx_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .result_valid     (result_valid),
      .result           (result)
   );

   scfp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept && result_valid),
      .in_data   (result),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_frame_status    = rsp_data.frame_status;
   assign rsp_message_id      = rsp_data.message_id;
   assign rsp_sequence_res    = rsp_data.sequence_res;
   assign rsp_frame_length    = rsp_data.frame_length;
   assign rsp_heartbeat_count = rsp_data.heartbeat_count;
   assign rsp_gimbal_count    = rsp_data.gimbal_count;

endmodule
